// ===== hw/rtl/ptb_pkg.sv =====
`timescale 1ns / 1ps
package ptb_pkg;
	localparam int SYM_W    = 8;
	localparam int IDX_W    = 13;
	localparam int MAX_LEN  = 4096;
	localparam int TEXT_CAP = MAX_LEN + 1;
	localparam int NODE_CAP = MAX_LEN + 2;
	localparam int QDEPTH   = 2;

	localparam logic [IDX_W-1:0] ROOT_EMPTY = IDX_W'(0);
	localparam logic [IDX_W-1:0] ROOT_IMAG  = IDX_W'(1);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             new_string;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_WLEN, ST_WPOS, ST_WCMP, ST_FFC, ST_FKSEL,
		ST_FK, ST_FCMP, ST_CNT, ST_MAKE, ST_LINK, ST_RD, ST_EMIT
	} bstate_t;
endpackage

// ===== hw/rtl/ptb_front.sv =====
`timescale 1ns / 1ps
module ptb_front import ptb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SYM_W-1:0] in_symbol,
	input  logic             in_new_string,
	output q_out_t           q_out,
	input  logic             q_pop
);
	item_t      slot_q [QDEPTH];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	item_t      incoming;

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && (cnt_q != 2'd0);
	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.item  = slot_q[rd_q];

	always_comb begin
		incoming.symbol     = in_symbol;
		incoming.new_string = in_new_string;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hw/rtl/ptb_back.sv =====
`timescale 1ns / 1ps
module ptb_back import ptb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  q_out_t           q_out,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] out_count,
	output logic [IDX_W-1:0] out_length,
	output logic [IDX_W-1:0] out_node,
	output logic             out_overflow
);
	bstate_t state_q, state_d;

	logic [SYM_W-1:0] text_mem [TEXT_CAP];
	logic [IDX_W-1:0] len_mem  [NODE_CAP];
	logic [IDX_W-1:0] link_mem [NODE_CAP];
	logic [IDX_W-1:0] cnt_mem  [NODE_CAP];
	logic [SYM_W-1:0] edge_mem [NODE_CAP];
	logic [IDX_W-1:0] fc_mem   [NODE_CAP];
	logic [IDX_W-1:0] nxt_mem  [NODE_CAP];

	logic [SYM_W-1:0] text_rd, edge_rd;
	logic [IDX_W-1:0] len_rd, link_rd, cnt_rd, fc_rd, nxt_rd;
	logic [IDX_W-1:0] node_ra, text_ra;

	logic [IDX_W-1:0] text_len_q, cur_q, total_q, fc0_q, fc1_q;
	logic [SYM_W-1:0] c_q;
	logic [IDX_W-1:0] v_q, k_q, link_hold_q, cur_w_q, link_cur_q, fc_cur_q;
	logic [IDX_W-1:0] link_new_q, node_q;
	logic [IDX_W:0]   len_hold_q, len_cur_q;
	logic             phase_q;

	logic             start_ok;
	logic             overflow_hit;
	logic [IDX_W:0]   lenv, pos;
	logic [IDX_W-1:0] linkv, kv, fresh_cnt, fresh_len;
	logic             pos_bad, walk_hit, fk_end, fc_hit;

	assign start_ok     = q_out.valid && (!out_valid || out_ready);
	assign overflow_hit = (text_len_q >= IDX_W'(TEXT_CAP));

	// Roots never live in node memories; their len and link are constants.
	always_comb begin
		case (v_q)
			ROOT_EMPTY: begin lenv = '0;        linkv = ROOT_IMAG;  end
			ROOT_IMAG:  begin lenv = '1;        linkv = ROOT_EMPTY; end
			default:    begin lenv = {1'b0, len_rd}; linkv = link_rd; end
		endcase
		pos       = {1'b0, text_len_q} - (IDX_W+1)'(2) - lenv;
		pos_bad   = pos[IDX_W] || (pos == '0);
		walk_hit  = (text_rd == c_q);
		case (v_q)
			ROOT_EMPTY: kv = fc0_q;
			ROOT_IMAG:  kv = fc1_q;
			default:    kv = fc_rd;
		endcase
		fk_end    = (k_q == '0);
		fc_hit    = (edge_rd == c_q);
		fresh_cnt = ((link_new_q == ROOT_EMPTY || link_new_q == ROOT_IMAG) ? '0 : cnt_rd)
			+ IDX_W'(1);
		fresh_len = len_cur_q[IDX_W-1:0] + IDX_W'(2);
	end

	always_comb begin
		case (state_q)
			ST_FK:   node_ra = k_q;
			ST_CNT:  node_ra = link_new_q;
			ST_RD:   node_ra = node_q;
			default: node_ra = v_q;
		endcase
		text_ra = pos[IDX_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start_ok) begin state_d = ST_START; end
			ST_START: state_d = overflow_hit ? ST_IDLE : ST_WLEN;
			ST_WLEN:  state_d = ST_WPOS;
			ST_WPOS:  state_d = pos_bad ? ST_WLEN : ST_WCMP;
			ST_WCMP:  state_d = walk_hit ? ST_FFC : ST_WLEN;
			ST_FFC:   state_d = ST_FKSEL;
			ST_FKSEL: state_d = ST_FK;
			ST_FK: begin
				if (!fk_end) begin
					state_d = ST_FCMP;
				end else if (phase_q || cur_w_q == ROOT_IMAG) begin
					state_d = ST_CNT;
				end else begin
					state_d = ST_WLEN;
				end
			end
			ST_FCMP: begin
				if (!fc_hit) begin
					state_d = ST_FK;
				end else begin
					state_d = phase_q ? ST_CNT : ST_RD;
				end
			end
			ST_CNT:   state_d = ST_MAKE;
			ST_MAKE:  state_d = ST_LINK;
			ST_LINK:  state_d = ST_IDLE;
			ST_RD:    state_d = ST_EMIT;
			ST_EMIT:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == ST_IDLE) && start_ok;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START && !overflow_hit) begin
			text_mem[text_len_q] <= c_q;
		end
		text_rd <= text_mem[text_ra];
		if (state_q == ST_MAKE) begin
			len_mem[total_q]  <= fresh_len;
			link_mem[total_q] <= link_new_q;
			cnt_mem[total_q]  <= fresh_cnt;
			edge_mem[total_q] <= c_q;
			nxt_mem[total_q]  <= fc_cur_q;
			fc_mem[total_q]   <= '0;
		end else if (state_q == ST_LINK && cur_w_q != ROOT_EMPTY && cur_w_q != ROOT_IMAG) begin
			fc_mem[cur_w_q] <= total_q;
		end
		len_rd  <= len_mem[node_ra];
		link_rd <= link_mem[node_ra];
		cnt_rd  <= cnt_mem[node_ra];
		edge_rd <= edge_mem[node_ra];
		fc_rd   <= fc_mem[node_ra];
		nxt_rd  <= nxt_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:  c_q <= q_out.item.symbol;
			ST_START: begin v_q <= cur_q; phase_q <= 1'b0; end
			ST_WPOS: begin
				link_hold_q <= linkv;
				len_hold_q  <= lenv;
				if (pos_bad) begin
					v_q <= linkv;
				end
			end
			ST_WCMP: begin
				if (walk_hit && !phase_q) begin
					cur_w_q    <= v_q;
					len_cur_q  <= len_hold_q;
					link_cur_q <= link_hold_q;
				end else if (!walk_hit) begin
					v_q <= link_hold_q;
				end
			end
			ST_FKSEL: begin
				k_q <= kv;
				if (!phase_q) begin
					fc_cur_q <= kv;
				end
			end
			ST_FK: begin
				if (fk_end) begin
					if (phase_q || cur_w_q == ROOT_IMAG) begin
						link_new_q <= ROOT_EMPTY;
					end else begin
						phase_q <= 1'b1;
						v_q     <= link_cur_q;
					end
				end
			end
			ST_FCMP: begin
				if (!fc_hit) begin
					k_q <= nxt_rd;
				end else if (phase_q) begin
					link_new_q <= k_q;
				end else begin
					node_q <= k_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			text_len_q   <= IDX_W'(1);
			cur_q        <= ROOT_EMPTY;
			total_q      <= IDX_W'(2);
			fc0_q        <= '0;
			fc1_q        <= '0;
			out_valid    <= 1'b0;
			out_count    <= '0;
			out_length   <= '0;
			out_node     <= '0;
			out_overflow <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start_ok && q_out.item.new_string) begin
						text_len_q <= IDX_W'(1);
						cur_q      <= ROOT_EMPTY;
						total_q    <= IDX_W'(2);
						fc0_q      <= '0;
						fc1_q      <= '0;
					end
				end
				ST_START: begin
					if (overflow_hit) begin
						out_valid    <= 1'b1;
						out_count    <= '0;
						out_length   <= '0;
						out_node     <= '0;
						out_overflow <= 1'b1;
					end else begin
						text_len_q <= text_len_q + IDX_W'(1);
					end
				end
				ST_MAKE: begin
					out_valid    <= 1'b1;
					out_count    <= fresh_cnt;
					out_length   <= fresh_len;
					out_node     <= total_q;
					out_overflow <= 1'b0;
					cur_q        <= total_q;
				end
				ST_LINK: begin
					if (cur_w_q == ROOT_EMPTY) begin
						fc0_q <= total_q;
					end else if (cur_w_q == ROOT_IMAG) begin
						fc1_q <= total_q;
					end
					total_q <= total_q + IDX_W'(1);
				end
				ST_EMIT: begin
					out_valid    <= 1'b1;
					out_count    <= cnt_rd;
					out_length   <= len_rd;
					out_node     <= node_q;
					out_overflow <= 1'b0;
					cur_q        <= node_q;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/palindromic_tree_builder_unit.sv =====
`timescale 1ns / 1ps
// Builds a palindromic tree over the incoming symbol stream and returns one result per symbol:
// the number of palindromes ending at the new position, the longest one's length and its node.
// Each symbol's time grows with every node visited on the suffix-link walk (less where the
// mirrored position falls outside the text) and with every sibling passed over in the child
// list. When a new node needs its suffix link from a second walk, that walk adds its own
// per-node and per-sibling costs. A dropped symbol skips the walks. These steps are bound by
// the single read port of the node and text memories.
// A two-entry request queue lets the sender run ahead, but the back end starts the next
// request only once the previous result has been taken. A request with the new-string flag
// empties the tree before its symbol is added. Once 4096 symbols are stored, further symbols
// are dropped with the overflow flag set and all result fields zero.
module palindromic_tree_builder_unit import ptb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // symbol
	input  logic        s_tuser,  // new_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // palindrome_count, longest_length, node_index, zero fill
	output logic        m_tuser   // overflow
);
	q_out_t           q_out;
	logic             q_pop;
	logic [IDX_W-1:0] count, length, node;

	ptb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_symbol    (s_tdata),
		.in_new_string(s_tuser),
		.q_out        (q_out),
		.q_pop        (q_pop)
	);

	ptb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_out       (q_out),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_count   (count),
		.out_length  (length),
		.out_node    (node),
		.out_overflow(m_tuser)
	);

	assign m_tdata = {1'b0, node, length, count};
endmodule

// ===== hw/rtl/ptb_checker.sv =====
`timescale 1ns / 1ps
module ptb_props (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 40'd0)
		else $error("overflow result carries nonzero fields");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[12:0] != 13'd0 && m_tdata[25:13] != 13'd0
			&& m_tdata[38:27] != 12'd0)
		else $error("result without palindrome or with a root node");

	a_count_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[12:0] <= m_tdata[25:13])
		else $error("palindrome count exceeds longest length");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");
endmodule

bind palindromic_tree_builder_unit ptb_props u_ptb_props (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
